// ----- hw/rtl/usv_pkg.sv -----
package usv_pkg;

    // decode state carried from one byte to the next
    typedef struct packed {
        logic        fault_seen;
        logic [1:0]  bytes_left;
        logic [20:0] partial_value;
        logic [1:0]  sequence_length;
    } cp_state_t;

    // control_policy bit positions
    localparam int unsigned POL_REJECT_C0  = 0;
    localparam int unsigned POL_ALLOW_WS   = 1;
    localparam int unsigned POL_REJECT_DEL = 2;
    localparam int unsigned POL_REJECT_C1  = 3;

    localparam int unsigned POLICY_W = 4;

    // register file layout
    localparam int unsigned ADDR_W       = 3;
    localparam int unsigned DATA_W       = 32;
    localparam logic        IDX_POLICY   = 1'b0;

    // scalar value limits
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN1   = 21'h000080;
    localparam logic [20:0] MIN_LEN2   = 21'h000800;
    localparam logic [20:0] MIN_LEN3   = 21'h010000;
    localparam logic [20:0] C0_END     = 21'h000020;
    localparam logic [20:0] CP_TAB     = 21'h000009;
    localparam logic [20:0] CP_LF      = 21'h00000A;
    localparam logic [20:0] CP_CR      = 21'h00000D;
    localparam logic [20:0] CP_DEL     = 21'h00007F;
    localparam logic [20:0] C1_FIRST   = 21'h000080;
    localparam logic [20:0] C1_LAST    = 21'h00009F;

endpackage

// ----- hw/rtl/usv_stream_if.sv -----
interface usv_byte_if;
    logic       valid;
    logic       ready;
    logic       byte_present;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output byte_present, output data_byte,
                    output end_of_buffer, input ready);
    modport sink (input valid, input byte_present, input data_byte,
                  input end_of_buffer, output ready);
endinterface

interface usv_verdict_if;
    logic valid;
    logic ready;
    logic text_valid;

    modport source (output valid, output text_valid, input ready);
    modport sink (input valid, input text_valid, output ready);
endinterface

// ----- hw/rtl/usv_decode.sv -----
module usv_decode (
    input  logic [usv_pkg::POLICY_W-1:0] policy,
    input  usv_pkg::cp_state_t           cur,
    input  logic [7:0]                   data_byte,
    output usv_pkg::cp_state_t           nxt
);

    function automatic logic permits(input logic [usv_pkg::POLICY_W-1:0] pol,
                                     input logic [20:0] cp);
        logic ok;
        begin
            ok = 1'b1;
            if (pol[usv_pkg::POL_REJECT_C0] && cp < usv_pkg::C0_END)
            begin
                ok = pol[usv_pkg::POL_ALLOW_WS] &&
                     (cp == usv_pkg::CP_TAB || cp == usv_pkg::CP_LF ||
                      cp == usv_pkg::CP_CR);
            end
            else if (pol[usv_pkg::POL_REJECT_DEL] && cp == usv_pkg::CP_DEL)
            begin
                ok = 1'b0;
            end
            else if (pol[usv_pkg::POL_REJECT_C1] && cp >= usv_pkg::C1_FIRST &&
                     cp <= usv_pkg::C1_LAST)
            begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

    logic [20:0] pv_shift;
    logic [1:0]  bl_dec;
    logic [20:0] min_value;

    assign pv_shift = {cur.partial_value[14:0], data_byte[5:0]};
    assign bl_dec   = cur.bytes_left - 2'd1;

    // overlong floor for the character length
    always_comb
    begin
        case (cur.sequence_length)
            2'd1:    min_value = usv_pkg::MIN_LEN1;
            2'd2:    min_value = usv_pkg::MIN_LEN2;
            default: min_value = usv_pkg::MIN_LEN3;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (!cur.fault_seen)
        begin
            if (cur.bytes_left == 2'd0)
            begin
                // lead byte
                if (!data_byte[7])
                begin
                    if (!permits(policy, {13'd0, data_byte}))
                        nxt.fault_seen = 1'b1;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    nxt.partial_value   = {16'd0, data_byte[4:0]};
                    nxt.sequence_length = 2'd1;
                    nxt.bytes_left      = 2'd1;
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    nxt.partial_value   = {17'd0, data_byte[3:0]};
                    nxt.sequence_length = 2'd2;
                    nxt.bytes_left      = 2'd2;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    nxt.partial_value   = {18'd0, data_byte[2:0]};
                    nxt.sequence_length = 2'd3;
                    nxt.bytes_left      = 2'd3;
                end
                else
                begin
                    nxt.fault_seen = 1'b1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                nxt.fault_seen = 1'b1;
            end
            else
            begin
                nxt.partial_value = pv_shift;
                nxt.bytes_left    = bl_dec;
                if (bl_dec == 2'd0)
                begin
                    // character complete: range, surrogate and policy checks
                    if (pv_shift < min_value || pv_shift > usv_pkg::MAX_SCALAR ||
                        (pv_shift >= usv_pkg::SURR_LO && pv_shift <= usv_pkg::SURR_HI) ||
                        !permits(policy, pv_shift))
                        nxt.fault_seen = 1'b1;
                    nxt.partial_value   = 21'd0;
                    nxt.sequence_length = 2'd0;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/utf8_stream_validator.sv -----
// utf8 stream validator: checks a byte stream buffer by buffer
// the last item of a buffer passes the input register, then its verdict
//   goes to the verdict register; it stalls while a verdict is still held
// rate: one item per cycle save that stall, one combinational decode per byte
// reset: rst_n asynchronous active low, clears decode state, pipeline valids
//   and control_policy

module utf8_stream_validator (
    input  logic                         clk,
    input  logic                         rst_n,
    usv_byte_if.sink                     byte_in,
    usv_verdict_if.source                verdict_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [usv_pkg::ADDR_W-1:0]   paddr,
    input  logic [usv_pkg::DATA_W-1:0]   pwdata,
    output logic [usv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // configuration register
    logic [usv_pkg::POLICY_W-1:0] policy_reg;
    logic                         cfg_write;

    // input register stage
    logic       s1_valid_reg;
    logic       s1_present_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       s1_advance;

    // running decode state
    usv_pkg::cp_state_t state_reg;
    usv_pkg::cp_state_t state_next;
    usv_pkg::cp_state_t dec_state;
    usv_pkg::cp_state_t after_byte;

    // verdict register
    logic out_valid_reg;
    logic out_valid_next;
    logic out_text_reg;
    logic verdict;

    // apb: zero wait states, one register at index 0, low address bits ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[usv_pkg::ADDR_W-1:2] == usv_pkg::IDX_POLICY);
    assign prdata    = {{(usv_pkg::DATA_W-usv_pkg::POLICY_W){1'b0}}, policy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= '0;
        else if (cfg_write)
            policy_reg <= pwdata[usv_pkg::POLICY_W-1:0];
    end

    // an item in the input register moves on unless it carries a verdict
    // and the verdict register is still held by the sink
    assign s1_advance    = s1_valid_reg &&
                           (!s1_end_reg || !out_valid_reg || verdict_out.ready);
    assign byte_in.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_in.ready)
            s1_valid_reg <= byte_in.valid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_present_reg <= byte_in.byte_present;
            s1_byte_reg    <= byte_in.data_byte;
            s1_end_reg     <= byte_in.end_of_buffer;
        end
    end

    usv_decode u_decode (
        .policy    (policy_reg),
        .cur       (state_reg),
        .data_byte (s1_byte_reg),
        .nxt       (dec_state)
    );

    // an item without a byte leaves the state alone
    assign after_byte = s1_present_reg ? dec_state : state_reg;
    assign verdict    = !after_byte.fault_seen && (after_byte.bytes_left == 2'd0);

    always_comb
    begin
        state_next = state_reg;
        if (s1_advance)
        begin
            // end of buffer: verdict taken, state back to its reset value
            if (s1_end_reg)
                state_next = '0;
            else
                state_next = after_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_end_reg)
            out_valid_next = 1'b1;
        else if (verdict_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_end_reg)
            out_text_reg <= verdict;
    end

    assign verdict_out.valid      = out_valid_reg;
    assign verdict_out.text_valid = out_text_reg;

endmodule

// ----- hw/rtl/usv_checker.sv -----
module usv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_end,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_text,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [usv_pkg::ADDR_W-1:0]   paddr,
    input logic [usv_pkg::DATA_W-1:0]   pwdata,
    input logic [usv_pkg::DATA_W-1:0]   prdata
);

    // a held verdict keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_text))
        else $error("verdict changed while stalled");

    // input side never blocks while the verdict register is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty verdict register");

    // a new verdict follows an accepted end item, by way of the input and verdict registers
    a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_end, 2))
        else $error("verdict without end of buffer");

    // policy write is read back
    a_policy_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[usv_pkg::ADDR_W-1:2] == usv_pkg::IDX_POLICY)
        |=> prdata[usv_pkg::POLICY_W-1:0] == $past(pwdata[usv_pkg::POLICY_W-1:0]))
        else $error("policy readback mismatch");

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_end    (byte_in.end_of_buffer),
    .out_valid (verdict_out.valid),
    .out_ready (verdict_out.ready),
    .out_text  (verdict_out.text_valid),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
